// ===== hw/rtl/slid_pkg.sv =====
// shared types and constants for the sorted list store
// no dependencies; imported by slid_cell and sorted_list_insert_delete
package slid_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                     we;
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/slid_cell.sv =====
// one slot of the sorted chain: holds an entry, compares it with the
// broadcast value and shifts toward either neighbor; uses slid_pkg
module slid_cell (
  input  logic                              clk_i,
  input  slid_pkg::cell_ctrl_t              ctrl_i,
  input  logic                              occupied_i,
  input  logic                              left_lt_i,
  input  logic signed [slid_pkg::DATA_W-1:0] left_entry_i,
  input  logic signed [slid_pkg::DATA_W-1:0] right_entry_i,
  output logic                              lt_o,
  output logic                              hit_o,
  output logic signed [slid_pkg::DATA_W-1:0] entry_o,
  output logic signed [slid_pkg::DATA_W-1:0] entry_d_o
);
  import slid_pkg::*;

  logic signed [DATA_W-1:0] entry_q, entry_d;

  assign lt_o  = occupied_i && (entry_q < ctrl_i.value);
  // first entry not below the value, and equal to it
  assign hit_o = occupied_i && left_lt_i && !lt_o && (entry_q == ctrl_i.value);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.we && !lt_o) begin
      case (ctrl_i.cmd)
        CMD_INSERT: entry_d = left_lt_i ? ctrl_i.value : left_entry_i;
        CMD_DELETE: entry_d = right_entry_i;
        default:    entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

// ===== hw/rtl/sorted_list_insert_delete.sv =====
// sorted multiset store built as a row of compare-and-shift cells
// output: the result of each accepted transaction is registered
// throughput: one transaction per cycle while the registered result is not stalled
// reset: count cleared and output register empty; entries hold no reset value
// depends on slid_pkg and slid_cell
module sorted_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [0:0]                          in_cmd_i,
  input  logic signed [slid_pkg::DATA_W-1:0]  in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          out_status_o,
  output logic [slid_pkg::COUNT_W-1:0]        out_count_after_o,
  output logic                                out_is_empty_o,
  output logic signed [slid_pkg::DATA_W-1:0]  out_smallest_o
);
  import slid_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                     accept;
  logic                     is_insert;
  logic                     full;
  logic                     found;
  logic                     op_ok;
  logic [CW-1:0]            count_q, count_d;
  cell_ctrl_t               ctrl;
  status_e                  status_d;

  logic [CAPACITY-1:0]      occ, lt, hit;
  logic signed [DATA_W-1:0] entry   [CAPACITY];
  logic signed [DATA_W-1:0] entry_d [CAPACITY];

  logic                     out_valid_q;
  logic [1:0]               status_q;
  logic [COUNT_W-1:0]       count_after_q;
  logic                     is_empty_q;
  logic signed [DATA_W-1:0] smallest_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_insert  = (cmd_e'(in_cmd_i) == CMD_INSERT);
  assign full       = (count_q == CW'(CAPACITY));
  assign found      = |hit;
  assign op_ok      = is_insert ? !full : found;

  assign ctrl.we    = accept && op_ok;
  assign ctrl.cmd   = cmd_e'(in_cmd_i);
  assign ctrl.value = in_value_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    logic                     left_lt;
    logic signed [DATA_W-1:0] left_entry, right_entry;

    assign occ[i] = (Idx < count_q);

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = in_value_i;
    end else begin : g_body
      assign left_lt    = lt[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    slid_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occ[i]),
      .left_lt_i    (left_lt),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .lt_o         (lt[i]),
      .hit_o        (hit[i]),
      .entry_o      (entry[i]),
      .entry_d_o    (entry_d[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    if (is_insert) begin
      if (full) status_d = ST_FULL;
      else      count_d  = count_q + CW'(1);
    end else begin
      if (!found) status_d = ST_NOT_FOUND;
      else        count_d  = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      count_after_q <= COUNT_W'(count_d);
      is_empty_q    <= (count_d == '0);
      smallest_q    <= (count_d == '0) ? '0 : entry_d[0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = status_q;
  assign out_count_after_o = count_after_q;
  assign out_is_empty_o    = is_empty_q;
  assign out_smallest_o    = smallest_q;

  // the store never grows past its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // at most one cell claims the delete position
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one matching cell");

  // an insert into a full store reports full and leaves the count alone
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_insert && full |=> out_status_o == ST_FULL && count_q == CW'(CAPACITY))
    else $error("insert into full store not refused");

  // a stalled result freezes the store
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(count_q))
    else $error("store changed while result stalled");

  // a failed delete leaves the count unchanged
  a_miss_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_insert && !found |=> out_status_o == ST_NOT_FOUND && $stable(count_q))
    else $error("missing delete changed the store");

endmodule

// ===== tb/slid_tb_pkg.sv =====
`timescale 1ns / 100ps
// scoreboard for the sorted list store: shadow copy of the list and expected results
// depends on slid_pkg for the command and status codes and the data width
package slid_tb_pkg;
  import slid_pkg::*;

  typedef struct packed {
    status_e                  status;
    logic [COUNT_W-1:0]       count_after;
    logic                     is_empty;
    logic signed [DATA_W-1:0] smallest;
  } list_result_t;

  class slid_scoreboard;
    int                       depth;
    logic signed [DATA_W-1:0] shadow_list[];
    int                       n_stored;
    list_result_t             expected_results[$];
    int unsigned              failures;

    function new(int list_depth);
      depth      = list_depth;
      shadow_list = new[list_depth];
      n_stored   = 0;
      failures   = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // a value currently in the list (zero if the list is empty), drawn for inserts and deletes alike
    function logic signed [DATA_W-1:0] any_stored();
      if (n_stored == 0) return '0;
      return shadow_list[$urandom_range(n_stored - 1)];
    endfunction

    // apply one accepted transaction to the shadow list and queue its result
    function void note_op(cmd_e cmd, logic signed [DATA_W-1:0] value);
      status_e      st;
      int           pos;
      int           k;
      list_result_t res;
      st  = ST_DONE;
      pos = 0;
      if (cmd == CMD_INSERT) begin
        if (n_stored >= depth) begin
          st = ST_FULL;
        end else begin
          while (pos < n_stored && shadow_list[pos] < value) pos++;
          for (k = n_stored; k > pos; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[pos] = value;
          n_stored++;
        end
      end else begin
        while (pos < n_stored && shadow_list[pos] != value) pos++;
        if (pos >= n_stored) begin
          st = ST_NOT_FOUND;
        end else begin
          for (k = pos; k + 1 < n_stored; k++) shadow_list[k] = shadow_list[k+1];
          n_stored--;
        end
      end
      res.status      = st;
      res.count_after = n_stored[COUNT_W-1:0];
      res.is_empty    = (n_stored == 0);
      res.smallest    = (n_stored == 0) ? '0 : shadow_list[0];
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [COUNT_W-1:0] count_after,
                               logic is_empty, logic signed [DATA_W-1:0] smallest);
      list_result_t exp;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d count %0d empty %0d smallest %0d",
                 $time, status, count_after, is_empty, smallest);
        failures++;
        return;
      end
      exp = expected_results.pop_front();
      if (exp.status !== status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
        failures++;
      end
      if (exp.count_after !== count_after) begin
        $display("%0t: count_after expected %0d actual %0d", $time, exp.count_after,
                 count_after);
        failures++;
      end
      if (exp.is_empty !== is_empty) begin
        $display("%0t: is_empty expected %0d actual %0d", $time, exp.is_empty, is_empty);
        failures++;
      end
      if (exp.smallest !== smallest) begin
        $display("%0t: smallest expected %0d actual %0d", $time, exp.smallest, smallest);
        failures++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_sorted_list_insert_delete.sv =====
`timescale 1ns / 100ps
// top-level testbench for sorted_list_insert_delete: directed and random inserts/deletes
// depends on slid_pkg, slid_tb_pkg and the block under test
module tb_sorted_list_insert_delete;
  import slid_pkg::*;
  import slid_tb_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int PHASE_ITEMS = 445;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_NS    = 2_000_000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [0:0]               in_cmd_i = 1'b0;
  logic signed [DATA_W-1:0] in_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [1:0]               out_status_o;
  logic [COUNT_W-1:0]       out_count_after_o;
  logic                     out_is_empty_o;
  logic signed [DATA_W-1:0] out_smallest_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned insert_pct     = 50;
  bit          hold_go        = 1'b0;
  int          hold_left      = 0;

  slid_scoreboard sb = new(LIST_DEPTH);

  sorted_list_insert_delete #(
    .CAPACITY(LIST_DEPTH)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_cmd_i         (in_cmd_i),
    .in_value_i       (in_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_status_o     (out_status_o),
    .out_count_after_o(out_count_after_o),
    .out_is_empty_o   (out_is_empty_o),
    .out_smallest_o   (out_smallest_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // offer one transaction, with random idle cycles ahead of it
  task automatic send_op(cmd_e cmd, logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_cmd_i   <= cmd;
    in_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_op(cmd, value);
    @(negedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return $signed(32'($urandom_range(15))) - 32'sd8;
    if (r < 60) begin
      case ($urandom_range(5))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh8000_0001;
        3: return 32'sh7fff_fffe;
        4: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (r < 80) return sb.any_stored();
    return $signed($urandom);
  endfunction

  task automatic run_random(int n_items);
    int   i;
    cmd_e cmd;
    for (i = 0; i < n_items; i++) begin
      // bursts that lean toward filling or draining the list
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 25;
          default: insert_pct = 50;
        endcase
      end
      cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
      send_op(cmd, pick_value());
    end
  endtask

  task automatic run_directed();
    int i;
    send_op(CMD_DELETE, 32'sd5);            // delete on empty list
    send_op(CMD_INSERT, 32'sh7fff_ffff);
    send_op(CMD_INSERT, 32'sh8000_0000);
    send_op(CMD_INSERT, 32'sd0);
    send_op(CMD_INSERT, -32'sd1);
    send_op(CMD_INSERT, 32'sd0);            // duplicate
    send_op(CMD_DELETE, 32'sh8000_0000);    // head goes, smallest moves up
    send_op(CMD_DELETE, 32'sd12345);        // absent value
    send_op(CMD_DELETE, 32'sh7fff_ffff);    // tail
    for (i = 0; i < 13; i++) send_op(CMD_INSERT, $signed(32'((i % 5) * 3)) - 32'sd5);
    send_op(CMD_INSERT, 32'sd1);            // list full
    send_op(CMD_INSERT, 32'sh8000_0000);
  endtask

  // receiver: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result(out_status_o, out_count_after_o, out_is_empty_o, out_smallest_o);
      @(negedge clk_i);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct  = 30;
    recv_stall_pct = 84;
    run_directed();
    run_random(PHASE_ITEMS);

    send_idle_pct  = 84;
    recv_stall_pct = 30;
    run_random(PHASE_ITEMS);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;
    run_random(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/slid_pkg.sv
hw/rtl/slid_cell.sv
hw/rtl/sorted_list_insert_delete.sv
tb/slid_tb_pkg.sv
tb/tb_sorted_list_insert_delete.sv
